@@ hdl/lfu_pkg.sv @@
`timescale 1ns / 1ps
// Package for the LFU cache table: field widths and reset constants.
// Depends on nothing; imported by lfu_cache_table_core.
package lfu_pkg;

    // Width of the per-entry use count; counts saturate at all ones.
    localparam int COUNT_BITS = 32;
    // Width of the access clock and of each entry's last-use stamp.
    localparam int STAMP_BITS = 48;
    // Width of the capacity register and its value after reset.
    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
    // Use count given to a freshly inserted key.
    localparam logic [COUNT_BITS-1:0] COUNT_FIRST = 32'd1;
    // Operation codes carried on the input tuser.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

endpackage

@@ hdl/lfu_cache_table_core.sv @@
`timescale 1ns / 1ps
// Key-value cache with least-frequently-used replacement and oldest-use tie break.
// Depends on lfu_pkg for widths, reset values and operation codes.

// Every transaction on the input stream is a get (tuser = 0) or a put (tuser = 1) of a
// key and a value, and it gives exactly one result transaction. The block works on one
// transaction at a time: after one is taken, a single compare unit walks the occupied
// entries through one read port of the entry memories, one entry per cycle, looking for
// the key and for the replacement victim (smallest use count, then oldest stamp, then
// lowest slot). The write state then writes the entry back and loads the result
// register once that register is free, so a stalled result only holds up the write-back
// of the following item. Entries fill from slot 0 upward and a victim's slot is refilled
// at once, so the occupied slots are always slots 0 to occ_reg-1 and no per-entry valid
// bits or clearing pass are needed. Lowering the capacity below the occupancy does not
// drop entries; each new key then evicts one entry. A capacity of zero acts as one and a
// capacity above ENTRIES acts as ENTRIES. The capacity register may be written at any
// time the block is idle; cfg_ready is always high, so a write is accepted when offered.
module lfu_cache_table_core
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Capacity register write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CAP_BITS-1:0]           cfg_data,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata from bit 0 up: key, value, zero fill to whole bytes.
    input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: op (0 get, 1 put).
    input  logic                          s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata from bit 0 up: read_value, evicted_key, zero fill to whole bytes.
    output logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] m_tdata,
    // tuser from bit 0 up: hit, evicted.
    output logic [1:0]                    m_tuser
);

    localparam int DATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // Entry memories: one write port and one registered read port each.
    logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];

    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_value_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;
    logic [STAMP_BITS-1:0] rd_stamp_reg;

    // Control state.
    state_t                state_reg;
    logic [CAP_BITS-1:0]   cap_reg;
    logic [CNT_W-1:0]      occ_reg;
    logic [STAMP_BITS-1:0] clock_reg;
    logic [CNT_W-1:0]      iss_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  found_reg;
    logic                  have_reg;
    logic                  m_tvalid_reg;
    logic [DATA_W-1:0]     m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    // Item and scan results (payload, no reset needed).
    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic [VALUE_BITS-1:0] found_value_reg;
    logic [COUNT_BITS-1:0] found_count_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [KEY_BITS-1:0]   best_key_reg;
    logic [COUNT_BITS-1:0] best_count_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;

    logic                  s_accept;
    logic                  iss_more;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  key_match;
    logic                  better;
    logic                  full;
    logic                  out_free;
    logic                  finish;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] wr_value;
    logic [COUNT_BITS-1:0] wr_count;
    logic                  res_hit;
    logic                  res_evicted;
    logic [VALUE_BITS-1:0] res_value;
    logic [KEY_BITS-1:0]   res_evk;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Scan side: issue one read per cycle, evaluate the entry read the cycle before.
    assign iss_more  = (iss_reg < occ_reg);
    assign rd_en     = (state_reg == ST_SCAN) && iss_more;
    assign rd_addr   = iss_reg[IDX_W-1:0];
    assign key_match = (rd_key_reg == key_reg);
    // The shared compare unit: victim order is count first, then stamp.
    assign better    = !have_reg || (rd_count_reg < best_count_reg) ||
                       ((rd_count_reg == best_count_reg) && (rd_stamp_reg < best_stamp_reg));

    // The cache is full when the occupancy has reached the effective capacity.
    always_comb
    begin
        if (occ_reg == CNT_W'(ENTRIES))
            full = 1'b1;
        else if (cap_reg == '0)
            full = (occ_reg != '0);
        else
            full = (CMP_W'(occ_reg) >= CMP_W'(cap_reg));
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_WRITE) && out_free;
    assign wr_en    = finish && (found_reg || (op_reg == OP_PUT));

    always_comb
    begin
        res_hit     = found_reg;
        res_evicted = !found_reg && (op_reg == OP_PUT) && full;
        res_value   = (found_reg && (op_reg == OP_GET)) ? found_value_reg : '0;
        res_evk     = res_evicted ? best_key_reg : '0;
        if (found_reg)
            wr_addr = found_idx_reg;
        else if (full)
            wr_addr = best_idx_reg;
        else
            wr_addr = occ_reg[IDX_W-1:0];
        wr_value = (found_reg && (op_reg == OP_GET)) ? found_value_reg : value_reg;
        if (!found_reg)
            wr_count = COUNT_FIRST;
        else if (found_count_reg == '1)
            wr_count = found_count_reg;
        else
            wr_count = found_count_reg + COUNT_FIRST;
    end

    // Entry memories.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= key_reg;
            value_mem[wr_addr] <= wr_value;
            count_mem[wr_addr] <= wr_count;
            stamp_mem[wr_addr] <= clock_reg;
        end
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_value_reg <= value_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

    // Item fields and scan results.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg    <= s_tuser;
            key_reg   <= s_tdata[KEY_BITS-1:0];
            value_reg <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
        if ((state_reg == ST_SCAN) && rd_vld_reg)
        begin
            if (key_match && !found_reg)
            begin
                found_idx_reg   <= rd_idx_reg;
                found_value_reg <= rd_value_reg;
                found_count_reg <= rd_count_reg;
            end
            if (better)
            begin
                best_idx_reg   <= rd_idx_reg;
                best_key_reg   <= rd_key_reg;
                best_count_reg <= rd_count_reg;
                best_stamp_reg <= rd_stamp_reg;
            end
        end
    end

    // Sequencer, occupancy, access clock and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            occ_reg      <= '0;
            clock_reg    <= '0;
            iss_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            found_reg    <= 1'b0;
            have_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            // A result taken in the cycle that loads the next one keeps tvalid high.
            if (m_tvalid_reg && m_tready && !finish)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        iss_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        found_reg  <= 1'b0;
                        have_reg   <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_vld_reg <= iss_more;
                    rd_idx_reg <= rd_addr;
                    if (iss_more)
                        iss_reg <= iss_reg + CNT_W'(1);
                    if (rd_vld_reg)
                    begin
                        if (key_match)
                            found_reg <= 1'b1;
                        have_reg <= 1'b1;
                    end
                    if (!iss_more && !rd_vld_reg)
                        state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= DATA_W'({res_evk, res_value});
                        m_tuser_reg  <= {res_evicted, res_hit};
                        if (!found_reg && (op_reg == OP_PUT) && !full)
                            occ_reg <= occ_reg + CNT_W'(1);
                        clock_reg <= clock_reg + STAMP_BITS'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/tb_lfu_cache_table_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lfu_cache_table_core: directed and random get/put traffic.
// Depends on lfu_pkg and the core; a built-in cache predictor checks every result.
module tb_lfu_cache_table_core;
    import lfu_pkg::*;

    localparam int ENTRIES        = 16;
    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 32;
    localparam int DATA_BITS      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 85;

    typedef struct packed {
        logic                  op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } cache_req_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } cache_resp_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CAP_BITS-1:0]   cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_BITS-1:0]  s_tdata = '0;
    logic                  s_tuser = OP_GET;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_BITS-1:0]  m_tdata;
    logic [1:0]            m_tuser;

    lfu_cache_table_core #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the cache contents, kept in step with accepted transactions.
    logic                  line_valid [ENTRIES];
    logic [KEY_BITS-1:0]   line_key   [ENTRIES];
    logic [VALUE_BITS-1:0] line_value [ENTRIES];
    logic [COUNT_BITS-1:0] line_count [ENTRIES];
    logic [STAMP_BITS-1:0] line_stamp [ENTRIES];
    logic [STAMP_BITS-1:0] access_clock = '0;
    int                    occupancy = 0;
    logic [CAP_BITS-1:0]   capacity_reg = CAP_RESET;

    cache_req_t  pending_reqs    [$];
    cache_resp_t predicted_resps [$];
    cache_req_t  next_req;

    int   errors = 0;
    int   results_seen = 0;
    int   idle_cycles = 0;
    logic in_taken = 1'b0;
    int   burst_left = 8;
    int   gap_left = 0;
    int   stall_requests = 0;
    int   stall_served = 0;
    int   hold_left = 0;
    int   ready_mode = 0;
    int   mode_left = 0;

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            line_valid[i] = 1'b0;
        end
    end

    // Applies one access to the shadow cache and returns the result it must produce.
    function automatic cache_resp_t predict_access(cache_req_t req);
        cache_resp_t resp;
        int          slot;
        int          eff_cap;
        bit          found;
        bit          have;
        resp    = '0;
        slot    = 0;
        found   = 1'b0;
        have    = 1'b0;
        eff_cap = (capacity_reg == 0) ? 1 : ((capacity_reg > ENTRIES) ? ENTRIES : capacity_reg);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!found && line_valid[i] && line_key[i] == req.key)
            begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            resp.hit = 1'b1;
            if (req.op == OP_GET)
                resp.read_value = line_value[slot];
            else
                line_value[slot] = req.value;
            if (line_count[slot] != '1)
                line_count[slot] = line_count[slot] + COUNT_FIRST;
            line_stamp[slot] = access_clock;
        end
        else if (req.op == OP_PUT)
        begin
            if (occupancy >= eff_cap)
            begin
                // Victim: smallest count, then oldest stamp, then lowest slot.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (line_valid[i] && (!have || line_count[i] < line_count[slot] ||
                        (line_count[i] == line_count[slot] &&
                         line_stamp[i] < line_stamp[slot])))
                    begin
                        slot = i;
                        have = 1'b1;
                    end
                end
                if (have)
                begin
                    resp.evicted     = 1'b1;
                    resp.evicted_key = line_key[slot];
                    line_valid[slot] = 1'b0;
                    occupancy--;
                end
            end
            else
            begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!line_valid[i])
                        slot = i;
                end
            end
            if (!line_valid[slot])
            begin
                line_valid[slot] = 1'b1;
                line_key[slot]   = req.key;
                line_value[slot] = req.value;
                line_count[slot] = COUNT_FIRST;
                line_stamp[slot] = access_clock;
                occupancy++;
            end
        end
        access_clock = access_clock + STAMP_BITS'(1);
        return resp;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: result %0d %s mismatch: got %h, want %h",
                 $time, results_seen, field, got, want);
        errors++;
    endtask

    // Input driver: bursts of transactions separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                next_req = pending_reqs.pop_front();
                s_tuser  <= next_req.op;
                s_tdata  <= DATA_BITS'({next_req.value, next_req.key});
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
                                                              : $urandom_range(0, 3);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random ready patterns, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (stall_served != stall_requests)
        begin
            stall_served <= stall_served + 1;
            hold_left    <= LONG_HOLD;
            m_tready     <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(5, 60);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor: predicts on each accepted input and checks each accepted result.
    always @(posedge clk)
    begin
        cache_resp_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                predicted_resps.push_back(predict_access(
                    cache_req_t'{s_tuser, s_tdata[0 +: KEY_BITS],
                                 s_tdata[KEY_BITS +: VALUE_BITS]}));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (predicted_resps.size() == 0)
                begin
                    $display("%0t: result %0d arrived with nothing outstanding",
                             $time, results_seen);
                    errors++;
                end
                else
                begin
                    want = predicted_resps.pop_front();
                    if (m_tuser[0] !== want.hit)
                        report_mismatch("hit", m_tuser[0], want.hit);
                    if (m_tdata[0 +: VALUE_BITS] !== want.read_value)
                        report_mismatch("read_value", m_tdata[0 +: VALUE_BITS],
                                        want.read_value);
                    if (m_tuser[1] !== want.evicted)
                        report_mismatch("evicted", m_tuser[1], want.evicted);
                    if (m_tdata[VALUE_BITS +: KEY_BITS] !== want.evicted_key)
                        report_mismatch("evicted_key", m_tdata[VALUE_BITS +: KEY_BITS],
                                        want.evicted_key);
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("lfu_cache_table_core regression: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_req(input logic op, input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_BITS-1:0] value);
        pending_reqs.push_back(cache_req_t'{op, key, value});
    endtask

    // Sender holds back until every outstanding result has been received.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || predicted_resps.size() != 0 || s_tvalid);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        wait_idle();
        @(negedge clk);
        cfg_data  <= cap;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity_reg = cap;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random phase: keys drawn mostly from a pool a little larger than the capacity,
    // so that hits, updates and evictions all happen often.
    task automatic random_phase(input logic [CAP_BITS-1:0] cap, input bit pause_midway,
                                input bit long_stall);
        logic [KEY_BITS-1:0] pool [$];
        logic [KEY_BITS-1:0] key;
        int                  eff_cap;
        int                  pool_len;
        write_capacity(cap);
        eff_cap  = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
        pool_len = eff_cap + $urandom_range(1, eff_cap + 3);
        for (int i = 0; i < pool_len; i++)
        begin
            case ($urandom_range(0, 15))
                0:       pool.push_back('0);
                1:       pool.push_back('1);
                default: pool.push_back($urandom);
            endcase
        end
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = pool[$urandom_range(0, pool_len - 1)];
            push_req(($urandom_range(0, 4) < 3) ? OP_PUT : OP_GET, key, $urandom);
            if (pause_midway && i == PHASE_ITEMS / 2)
                wait_idle();
        end
        if (long_stall)
            stall_requests++;
    endtask

    initial
    begin
        logic [CAP_BITS-1:0] phase_caps [RANDOM_PHASES];
        phase_caps =
            '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd5, 5'd16, 5'd2, 5'd12, 5'd17, 5'd16};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty cache, extreme keys and values, update of a present key.
        push_req(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        push_req(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        push_req(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(OP_GET, 32'h0000_0000, 32'h1234_5678);
        push_req(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(OP_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
        push_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
        push_req(OP_GET, 32'h1234_5678, 32'h0000_0000);
        push_req(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
        push_req(OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);

        // Capacity lowered below occupancy: each new key evicts exactly one entry,
        // the lowest count first and the oldest among equal counts.
        write_capacity(5'd2);
        push_req(OP_PUT, 32'h0000_0001, 32'h0000_0011);
        push_req(OP_PUT, 32'h0000_0002, 32'h0000_0022);
        push_req(OP_GET, 32'h0000_0001, 32'h0000_0000);

        // A capacity of zero behaves as one.
        write_capacity(5'd0);
        push_req(OP_PUT, 32'h0000_0003, 32'h0000_0033);
        push_req(OP_PUT, 32'h0000_0004, 32'h0000_0044);
        push_req(OP_GET, 32'h0000_0003, 32'h0000_0000);

        // A capacity above the table size behaves as the table size.
        write_capacity(5'd31);
        push_req(OP_PUT, 32'h0000_0006, 32'h0000_0066);
        push_req(OP_PUT, 32'h0000_0007, 32'h0000_0077);
        push_req(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(phase_caps[p], p % 2 == 1, p == 2 || p == 7);

        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("lfu_cache_table_core regression: pass");
        else
            $display("lfu_cache_table_core regression: fail");
        $finish;
    end

endmodule
